// File: rtl/core/kss_pkg.sv
`default_nettype none

package kss_pkg;

  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 9;
  localparam int MAX_ITEMS_DEF = 256;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] selected_value;
    logic                      rank_error;
  } result_t;

  // One slot of the sorted chain; an empty slot orders above every value.
  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] key;
  } cell_data_t;

  typedef struct packed {
    logic insert;
    logic shift;
    logic flush;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/kss_cell.sv
`default_nettype none

module kss_cell
  import kss_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctrl_t                ctrl,
  input  logic signed [VALUE_W-1:0] x,
  input  cell_data_t                left,
  input  logic                      left_gt,
  input  cell_data_t                right,
  output cell_data_t                cur,
  output logic                      gt
);

  // New value belongs at or before this slot.
  assign gt = !cur.valid || (cur.key > x);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (ctrl.flush) begin
      cur.valid <= 1'b0;
    end else if (ctrl.insert) begin
      if (gt) begin
        if (!left_gt) begin
          cur.valid <= 1'b1;
          cur.key   <= x;
        end else begin
          cur <= left;
        end
      end
    end else if (ctrl.shift) begin
      cur <= right;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/kth_smallest_select_unit.sv
// Load: one item per cycle; each value is insertion-sorted into a chain of
// MAX_ITEMS cells in the cycle it is accepted, until the chain is full.
// Select: after the item marked last, the chain shifts toward cell 0 once
// per cycle for rank-1 shifts (none on a rank error); the result is then
// registered when the output is free. Items are stalled in selection only.
// Reset: synchronous; clears the cell valid bits, the count and the FSM.
`default_nettype none

module kth_smallest_select_unit
  import kss_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;

  typedef enum logic {
    LOAD,
    SELECT
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [RANK_W-1:0] remaining;
  logic              err;

  logic              item_acc;
  logic              do_insert;
  logic [CW-1:0]     count_next;
  logic              bad_rank;
  logic              done;
  logic              out_free;
  cell_ctrl_t        ctrl;

  cell_data_t        cell_q  [MAX_ITEMS];
  logic              cell_gt [MAX_ITEMS];

  // Accept only while loading; selection owns the chain otherwise.
  assign item_stall = (state != LOAD);
  assign item_acc   = item_valid && !item_stall;

  // Drop the value once the chain is full.
  assign do_insert  = item_acc && (count < CW'(MAX_ITEMS));
  assign count_next = count + CW'(do_insert);
  assign bad_rank   = (item.rank == '0) || (CMPW'(item.rank) > CMPW'(count_next));

  assign out_free = !result_valid || !result_stall;
  assign done     = (state == SELECT) && (err || remaining == '0) && out_free;

  always_comb begin
    ctrl.insert = do_insert;
    ctrl.shift  = (state == SELECT) && !err && (remaining != '0);
    ctrl.flush  = done;
  end

  // Sorted chain: cell 0 holds the smallest value.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_data_t left_d;
    cell_data_t right_d;
    logic       left_gt_d;

    if (i == 0) begin : g_first
      assign left_d    = '0;
      assign left_gt_d = 1'b0;
    end else begin : g_mid
      assign left_d    = cell_q[i-1];
      assign left_gt_d = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_body
      assign right_d = cell_q[i+1];
    end

    kss_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .x       (item.value),
      .left    (left_d),
      .left_gt (left_gt_d),
      .right   (right_d),
      .cur     (cell_q[i]),
      .gt      (cell_gt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= LOAD;
      count        <= '0;
      remaining    <= '0;
      err          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Retire a taken result first; a new one below overrides.
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (item_acc) begin
            if (item.last) begin
              // Start selection; the set's count clears for the next set.
              state     <= SELECT;
              count     <= '0;
              err       <= bad_rank;
              remaining <= item.rank - RANK_W'(1);
            end else begin
              count <= count_next;
            end
          end
        end
        SELECT: begin
          if (done) begin
            result_valid          <= 1'b1;
            result.rank_error     <= err;
            result.selected_value <= err ? '0 : cell_q[0].key;
            state                 <= LOAD;
          end else if (ctrl.shift) begin
            remaining <= remaining - RANK_W'(1);
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  // A flush leaves the chain empty.
  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    ctrl.flush |=> !cell_q[0].valid)
    else $error("chain not empty after flush");

  // With a legal rank the wanted value is always still in the chain.
  a_select_holds: assert property (@(posedge clk) disable iff (rst)
    (state == SELECT && !err) |-> cell_q[0].valid)
    else $error("chain ran empty during selection");

  // Count never passes the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("item count overflow");

  // An error result carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && err) |=> (result.rank_error && result.selected_value == '0))
    else $error("error result not zero");

endmodule

`default_nettype wire
